// File: rtl/core/ptc_pkg.sv
package ptc_pkg;

    // Default sizes
    localparam int COORD_BITS_DEF       = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    // Fraction bits of the closest point
    localparam int NEAR_FRAC = 8;

    // Region codes
    localparam logic [2:0] REG_A   = 3'd0;
    localparam logic [2:0] REG_B   = 3'd1;
    localparam logic [2:0] REG_AB  = 3'd2;
    localparam logic [2:0] REG_C   = 3'd3;
    localparam logic [2:0] REG_AC  = 3'd4;
    localparam logic [2:0] REG_BC  = 3'd5;
    localparam logic [2:0] REG_INT = 3'd6;

endpackage

// File: rtl/core/ptc_geom.sv
// Edge and offset vectors, per-axis products, then the six dot products.
module ptc_geom #(
    parameter int COORD_BITS = ptc_pkg::COORD_BITS_DEF,
    localparam int DW  = COORD_BITS + 1,
    localparam int PW  = 2 * DW,
    localparam int DTW = PW + 2
) (
    input  logic                   i_clk,
    input  logic [2:0]             i_en,
    input  logic [2:0][COORD_BITS-1:0] i_p,
    input  logic [2:0][COORD_BITS-1:0] i_a,
    input  logic [2:0][COORD_BITS-1:0] i_b,
    input  logic [2:0][COORD_BITS-1:0] i_c,
    output logic [2:0][DW-1:0]     o_ab,
    output logic [2:0][DW-1:0]     o_ac,
    output logic [2:0][DW-1:0]     o_bc,
    output logic [5:0][DTW-1:0]    o_d
);

    logic [2:0][DW-1:0] r_ab, r_ac, r_bc, r_ap, r_bp, r_cp;
    logic [2:0][DW-1:0] n_ab, n_ac, n_bc, n_ap, n_bp, n_cp;
    logic [5:0][2:0][PW-1:0] r_m, n_m;
    logic [5:0][DTW-1:0] r_d, n_d;

    // stage 0: differences
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ab[k] = DW'($signed(i_b[k])) - DW'($signed(i_a[k]));
            n_ac[k] = DW'($signed(i_c[k])) - DW'($signed(i_a[k]));
            n_bc[k] = DW'($signed(i_c[k])) - DW'($signed(i_b[k]));
            n_ap[k] = DW'($signed(i_p[k])) - DW'($signed(i_a[k]));
            n_bp[k] = DW'($signed(i_p[k])) - DW'($signed(i_b[k]));
            n_cp[k] = DW'($signed(i_p[k])) - DW'($signed(i_c[k]));
        end
    end

    // stage 1: per-axis products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_m[0][k] = PW'($signed(r_ab[k]) * $signed(r_ap[k]));
            n_m[1][k] = PW'($signed(r_ac[k]) * $signed(r_ap[k]));
            n_m[2][k] = PW'($signed(r_ab[k]) * $signed(r_bp[k]));
            n_m[3][k] = PW'($signed(r_ac[k]) * $signed(r_bp[k]));
            n_m[4][k] = PW'($signed(r_ab[k]) * $signed(r_cp[k]));
            n_m[5][k] = PW'($signed(r_ac[k]) * $signed(r_cp[k]));
        end
    end

    // stage 2: sums
    always_comb begin
        for (int j = 0; j < 6; j++) begin
            n_d[j] = DTW'($signed(r_m[j][0])) + DTW'($signed(r_m[j][1]))
                   + DTW'($signed(r_m[j][2]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ab <= n_ab;
            r_ac <= n_ac;
            r_bc <= n_bc;
            r_ap <= n_ap;
            r_bp <= n_bp;
            r_cp <= n_cp;
        end
        if (i_en[1]) begin
            r_m <= n_m;
        end
        if (i_en[2]) begin
            r_d <= n_d;
        end
    end

    assign o_ab = r_ab;
    assign o_ac = r_ac;
    assign o_bc = r_bc;
    assign o_d  = r_d;

endmodule

// File: rtl/core/ptc_xmul.sv
// Signed W x W multiply split in halves: partial products, then the sum.
module ptc_xmul #(
    parameter int W = 36,
    localparam int H  = (W + 1) / 2,
    localparam int HB = W - H,
    localparam int PRW = 2 * W
) (
    input  logic                  i_clk,
    input  logic [1:0]            i_en,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [PRW-1:0] o_p
);

    logic [H-1:0]          al, bl;
    logic signed [HB-1:0]  ah, bh;
    logic [2*H-1:0]        r_ll, n_ll;
    logic signed [H+HB:0]  r_lh, n_lh, r_hl, n_hl;
    logic signed [2*HB-1:0] r_hh, n_hh;
    logic signed [PRW-1:0] r_p, n_p;

    assign al = i_a[H-1:0];
    assign bl = i_b[H-1:0];
    assign ah = i_a[W-1:H];
    assign bh = i_b[W-1:H];

    // partial products
    always_comb begin
        n_ll = (2*H)'(al) * (2*H)'(bl);
        n_lh = (H+HB+1)'($signed({1'b0, al})) * (H+HB+1)'(bh);
        n_hl = (H+HB+1)'(ah) * (H+HB+1)'($signed({1'b0, bl}));
        n_hh = (2*HB)'(ah) * (2*HB)'(bh);
    end

    // recombine
    always_comb begin
        n_p = (PRW'(r_hh) <<< (2*H)) + (PRW'(r_lh) <<< H) + (PRW'(r_hl) <<< H)
            + $signed(PRW'(r_ll));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ll <= n_ll;
            r_lh <= n_lh;
            r_hl <= n_hl;
            r_hh <= n_hh;
        end
        if (i_en[1]) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// File: rtl/core/ptc_div.sv
// Fractional divide num/den, one quotient bit per stage.
// Gives 0 when num or den is not positive, one when num >= den.
module ptc_div #(
    parameter int XW  = 76,
    parameter int WFB = ptc_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic [WFB:0]         i_en,
    input  logic signed [XW-1:0] i_num,
    input  logic signed [XW-1:0] i_den,
    output logic [WFB:0]         o_q
);

    logic [XW-1:0]  r_rem [WFB+1];
    logic [XW-1:0]  n_rem [WFB+1];
    logic [XW-1:0]  r_den [WFB+1];
    logic [XW-1:0]  n_den [WFB+1];
    logic [WFB-1:0] r_q   [WFB+1];
    logic [WFB-1:0] n_q   [WFB+1];
    logic [WFB:0]   r_zero, n_zero, r_one, n_one;
    logic [XW-1:0]  sh    [WFB+1];

    always_comb begin
        // preamble: special cases
        n_zero[0] = (i_den <= XW'(0)) || (i_num <= XW'(0));
        n_one[0]  = !n_zero[0] && (i_num >= i_den);
        n_rem[0]  = i_num;
        n_den[0]  = i_den;
        n_q[0]    = '0;
        sh[0]     = '0;
        // restoring steps
        for (int s = 1; s <= WFB; s++) begin
            sh[s]     = {r_rem[s-1][XW-2:0], 1'b0};
            n_den[s]  = r_den[s-1];
            n_zero[s] = r_zero[s-1];
            n_one[s]  = r_one[s-1];
            if (sh[s] >= r_den[s-1]) begin
                n_rem[s] = sh[s] - r_den[s-1];
                n_q[s]   = {r_q[s-1][WFB-2:0], 1'b1};
            end else begin
                n_rem[s] = sh[s];
                n_q[s]   = {r_q[s-1][WFB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s <= WFB; s++) begin
            if (i_en[s]) begin
                r_rem[s]  <= n_rem[s];
                r_den[s]  <= n_den[s];
                r_q[s]    <= n_q[s];
                r_zero[s] <= n_zero[s];
                r_one[s]  <= n_one[s];
            end
        end
    end

    // final select
    always_comb begin
        if (r_zero[WFB]) begin
            o_q = '0;
        end else if (r_one[WFB]) begin
            o_q = {1'b1, {WFB{1'b0}}};
        end else begin
            o_q = {1'b0, r_q[WFB]};
        end
    end

endmodule

// File: rtl/core/point_triangle_closest_point_core.sv
// Closest point on triangle ABC to query point P. Fully pipelined: one item
// enters per cycle while the pipeline is not stalled, the bulk of the stages
// being the restoring divider that produces one weight bit per stage. Regions
// are tested in the order A, B, edge AB, C, edge AC, edge BC, interior;
// weights are Q1.WEIGHT_FRAC_BITS truncated, a degenerate denominator gives
// 0, and the closest point carries 8 fraction bits with the offset floored.
// Every stage holds its own valid bit, so a stall on the output squeezes out
// bubbles before it blocks the input.
module point_triangle_closest_point_core #(
    parameter int COORD_BITS       = ptc_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = ptc_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic signed [COORD_BITS-1:0] i_vert_a_x,
    input  logic signed [COORD_BITS-1:0] i_vert_a_y,
    input  logic signed [COORD_BITS-1:0] i_vert_a_z,
    input  logic signed [COORD_BITS-1:0] i_vert_b_x,
    input  logic signed [COORD_BITS-1:0] i_vert_b_y,
    input  logic signed [COORD_BITS-1:0] i_vert_b_z,
    input  logic signed [COORD_BITS-1:0] i_vert_c_x,
    input  logic signed [COORD_BITS-1:0] i_vert_c_y,
    input  logic signed [COORD_BITS-1:0] i_vert_c_z,
    output logic o_valid,
    input  logic i_stall,
    output logic signed [COORD_BITS+ptc_pkg::NEAR_FRAC-1:0] o_near_x,
    output logic signed [COORD_BITS+ptc_pkg::NEAR_FRAC-1:0] o_near_y,
    output logic signed [COORD_BITS+ptc_pkg::NEAR_FRAC-1:0] o_near_z,
    output logic [WEIGHT_FRAC_BITS:0] o_weight_b,
    output logic [WEIGHT_FRAC_BITS:0] o_weight_c,
    output logic [2:0] o_region
);

    localparam int CB  = COORD_BITS;
    localparam int WFB = WEIGHT_FRAC_BITS;
    localparam int NF  = ptc_pkg::NEAR_FRAC;
    localparam int NW  = CB + NF;
    localparam int DW  = CB + 1;
    localparam int DTW = 2 * DW + 2;
    localparam int XW  = 2 * DTW + 3;
    localparam int OW  = WFB + DW + 2;
    localparam int SW  = OW + 1;
    localparam int SH  = WFB - NF;
    // stage indexes
    localparam int S_XM  = 3;
    localparam int S_CR  = 5;
    localparam int S_RG  = 6;
    localparam int S_DV  = 7;
    localparam int S_WT  = WFB + 8;
    localparam int NS    = WFB + 10;

    typedef struct packed {
        logic [2:0][CB-1:0]  va;
        logic [2:0][CB-1:0]  vb;
        logic [2:0][CB-1:0]  vc;
        logic [2:0][DW-1:0]  ab;
        logic [2:0][DW-1:0]  ac;
        logic [2:0][DW-1:0]  bc;
        logic [5:0][DTW-1:0] d;
        logic [2:0]          region;
    } t_side;

    logic [NS-1:0] en;
    logic [NS-1:0] r_vld;
    t_side r_side [NS];
    t_side n_side [NS];

    // stage handshake: a stage loads when empty or when the next one loads
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[NS-1];

    // geometry front end
    logic [2:0][CB-1:0]  in_p, in_a, in_b, in_c;
    logic [2:0][DW-1:0]  g_ab, g_ac, g_bc;
    logic [5:0][DTW-1:0] g_d;

    assign in_p = {i_point_z, i_point_y, i_point_x};
    assign in_a = {i_vert_a_z, i_vert_a_y, i_vert_a_x};
    assign in_b = {i_vert_b_z, i_vert_b_y, i_vert_b_x};
    assign in_c = {i_vert_c_z, i_vert_c_y, i_vert_c_x};

    ptc_geom #(.COORD_BITS(CB)) u_geom (
        .i_clk (i_clk),
        .i_en  (en[2:0]),
        .i_p   (in_p),
        .i_a   (in_a),
        .i_b   (in_b),
        .i_c   (in_c),
        .o_ab  (g_ab),
        .o_ac  (g_ac),
        .o_bc  (g_bc),
        .o_d   (g_d)
    );

    // cross terms of the dot products
    logic signed [DTW-1:0]   xm_a [6];
    logic signed [DTW-1:0]   xm_b [6];
    logic signed [2*DTW-1:0] xm_p [6];

    always_comb begin
        // d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
        xm_a[0] = g_d[0]; xm_b[0] = g_d[3];
        xm_a[1] = g_d[2]; xm_b[1] = g_d[1];
        xm_a[2] = g_d[4]; xm_b[2] = g_d[1];
        xm_a[3] = g_d[0]; xm_b[3] = g_d[5];
        xm_a[4] = g_d[2]; xm_b[4] = g_d[5];
        xm_a[5] = g_d[4]; xm_b[5] = g_d[3];
    end

    for (genvar g = 0; g < 6; g++) begin : g_xm
        ptc_xmul #(.W(DTW)) u_xmul (
            .i_clk (i_clk),
            .i_en  (en[S_XM+1:S_XM]),
            .i_a   (xm_a[g]),
            .i_b   (xm_b[g]),
            .o_p   (xm_p[g])
        );
    end

    // region code of the item in the region test stage
    logic [2:0] n_region;

    // side data delay line
    always_comb begin
        n_side[0]    = '0;
        n_side[0].va = in_a;
        n_side[0].vb = in_b;
        n_side[0].vc = in_c;
        for (int k = 1; k < NS; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[1].ab = g_ab;
        n_side[1].ac = g_ac;
        n_side[1].bc = g_bc;
        n_side[S_XM].d = g_d;
        n_side[S_RG].region = n_region;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    // region numerators
    logic signed [XW-1:0] r_rcw, r_rb, r_ra, n_rcw, n_rb, n_ra;

    always_comb begin
        n_rcw = XW'(xm_p[0]) - XW'(xm_p[1]);
        n_rb  = XW'(xm_p[2]) - XW'(xm_p[3]);
        n_ra  = XW'(xm_p[4]) - XW'(xm_p[5]);
    end

    always_ff @(posedge i_clk) begin
        if (en[S_CR]) begin
            r_rcw <= n_rcw;
            r_rb  <= n_rb;
            r_ra  <= n_ra;
        end
    end

    // region tests and divide operands
    logic signed [DTW-1:0] d1, d2, d3, d4, d5, d6;
    logic signed [DTW:0]   d43, d56;
    logic signed [XW-1:0]  r_numb, r_numc, r_den, n_numb, n_numc, n_den;

    always_comb begin
        d1  = r_side[S_CR].d[0];
        d2  = r_side[S_CR].d[1];
        d3  = r_side[S_CR].d[2];
        d4  = r_side[S_CR].d[3];
        d5  = r_side[S_CR].d[4];
        d6  = r_side[S_CR].d[5];
        d43 = (DTW+1)'(d4) - (DTW+1)'(d3);
        d56 = (DTW+1)'(d5) - (DTW+1)'(d6);
        n_numb = '0;
        n_numc = '0;
        n_den  = '0;
        if (d1 <= DTW'(0) && d2 <= DTW'(0)) begin
            n_region = ptc_pkg::REG_A;
        end else if (d3 >= DTW'(0) && d4 <= d3) begin
            n_region = ptc_pkg::REG_B;
        end else if (r_rcw <= XW'(0) && d1 >= DTW'(0) && d3 <= DTW'(0)) begin
            n_region = ptc_pkg::REG_AB;
            n_numb   = XW'(d1);
            n_den    = XW'(d1) - XW'(d3);
        end else if (d6 >= DTW'(0) && d5 <= d6) begin
            n_region = ptc_pkg::REG_C;
        end else if (r_rb <= XW'(0) && d2 >= DTW'(0) && d6 <= DTW'(0)) begin
            n_region = ptc_pkg::REG_AC;
            n_numc   = XW'(d2);
            n_den    = XW'(d2) - XW'(d6);
        end else if (r_ra <= XW'(0) && d43 >= (DTW+1)'(0) && d56 >= (DTW+1)'(0)) begin
            n_region = ptc_pkg::REG_BC;
            n_numc   = XW'(d43);
            n_den    = XW'(d43) + XW'(d56);
        end else begin
            n_region = ptc_pkg::REG_INT;
            n_numb   = r_rb;
            n_numc   = r_rcw;
            n_den    = r_ra + r_rb + r_rcw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_RG]) begin
            r_numb <= n_numb;
            r_numc <= n_numc;
            r_den  <= n_den;
        end
    end

    // weight dividers
    logic [WFB:0] q_b, q_c;

    ptc_div #(.XW(XW), .WFB(WFB)) u_div_b (
        .i_clk (i_clk),
        .i_en  (en[S_DV+WFB:S_DV]),
        .i_num (r_numb),
        .i_den (r_den),
        .o_q   (q_b)
    );

    ptc_div #(.XW(XW), .WFB(WFB)) u_div_c (
        .i_clk (i_clk),
        .i_en  (en[S_DV+WFB:S_DV]),
        .i_num (r_numc),
        .i_den (r_den),
        .o_q   (q_c)
    );

    // weights, base vertex and offset products
    localparam logic [WFB:0] ONE = {1'b1, {WFB{1'b0}}};

    t_side                sd;
    logic [WFB:0]         n_wb, n_wc, w1, w2, r_wb, r_wc;
    logic [2:0][DW-1:0]   e1, e2;
    logic [2:0][CB-1:0]   n_base, r_base;
    logic [2:0][OW-1:0]   n_p1, n_p2, r_p1, r_p2;
    logic [2:0]           r_wregion;

    always_comb begin
        sd     = r_side[S_WT-1];
        n_wb   = '0;
        n_wc   = '0;
        w1     = '0;
        w2     = '0;
        e1     = sd.ab;
        e2     = sd.ac;
        n_base = sd.va;
        case (sd.region)
            ptc_pkg::REG_A: begin
                n_base = sd.va;
            end
            ptc_pkg::REG_B: begin
                n_wb   = ONE;
                n_base = sd.vb;
            end
            ptc_pkg::REG_AB: begin
                n_wb = q_b;
                w1   = q_b;
            end
            ptc_pkg::REG_C: begin
                n_wc   = ONE;
                n_base = sd.vc;
            end
            ptc_pkg::REG_AC: begin
                n_wc = q_c;
                w1   = q_c;
                e1   = sd.ac;
            end
            ptc_pkg::REG_BC: begin
                n_wc   = q_c;
                n_wb   = ONE - q_c;
                w1     = q_c;
                e1     = sd.bc;
                n_base = sd.vb;
            end
            default: begin
                n_wb = q_b;
                n_wc = q_c;
                w1   = q_b;
                w2   = q_c;
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            n_p1[k] = OW'($signed({1'b0, w1}) * $signed(e1[k]));
            n_p2[k] = OW'($signed({1'b0, w2}) * $signed(e2[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S_WT]) begin
            r_wb      <= n_wb;
            r_wc      <= n_wc;
            r_base    <= n_base;
            r_p1      <= n_p1;
            r_p2      <= n_p2;
            r_wregion <= sd.region;
        end
    end

    // closest point: base plus floored offset
    logic signed [SW-1:0] ofs [3];
    logic [2:0][NW-1:0]   n_near, r_near;
    logic [WFB:0]         r_owb, r_owc;
    logic [2:0]           r_oregion;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ofs[k]    = SW'($signed(r_p1[k])) + SW'($signed(r_p2[k]));
            n_near[k] = NW'(ofs[k] >>> SH) + {r_base[k], {NF{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_near    <= n_near;
            r_owb     <= r_wb;
            r_owc     <= r_wc;
            r_oregion <= r_wregion;
        end
    end

    assign o_near_x   = r_near[0];
    assign o_near_y   = r_near[1];
    assign o_near_z   = r_near[2];
    assign o_weight_b = r_owb;
    assign o_weight_c = r_owc;
    assign o_region   = r_oregion;

endmodule

// File: tb/sv/closest_point_checker.sv
`timescale 1ns / 100ps

module closest_point_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_stall,
    input  logic signed [15:0] i_coord [12],
    input  logic o_valid,
    input  logic i_stall,
    input  logic [23:0] o_near_x,
    input  logic [23:0] o_near_y,
    input  logic [23:0] o_near_z,
    input  logic [16:0] o_weight_b,
    input  logic [16:0] o_weight_c,
    input  logic [2:0] o_region,
    output int o_fail_count,
    output int o_pending
);

    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    typedef struct packed {
        logic [23:0] near_x;
        logic [23:0] near_y;
        logic [23:0] near_z;
        logic [16:0] weight_b;
        logic [16:0] weight_c;
        logic [2:0]  region;
    } t_near_point;

    t_near_point expected_points[$];

    // Restoring division num/den in Q1.16, truncated; non-positive operands give 0
    function automatic logic [16:0] weight_div(logic signed [127:0] num,
                                               logic signed [127:0] den);
        logic signed [127:0] rem;
        logic [16:0] q;
        if (den <= 0 || num <= 0) return '0;
        if (num >= den) return WEIGHT_ONE;
        rem = num;
        q = '0;
        for (int i = 0; i < 16; i++) begin
            rem = rem <<< 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint dot(longint ax, longint ay, longint az,
                                   longint bx, longint by, longint bz);
        return ax * bx + ay * by + az * bz;
    endfunction

    // Voronoi region classification and closest point
    function automatic t_near_point closest_point(logic signed [15:0] c [12]);
        longint pt[3], va[3], vb[3], vc[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        longint d1, d2, d3, d4, d5, d6, wbl, wcl;
        longint near[3];
        logic signed [127:0] e1, e2, e3, e4, e5, e6, area_a, area_b, area_c;
        logic [16:0] wb, wc;
        logic [2:0] reg_code;
        t_near_point res;
        for (int k = 0; k < 3; k++) begin
            pt[k] = c[k];
            va[k] = c[3 + k];
            vb[k] = c[6 + k];
            vc[k] = c[9 + k];
            ab[k] = vb[k] - va[k];
            ac[k] = vc[k] - va[k];
            bc[k] = vc[k] - vb[k];
            ap[k] = pt[k] - va[k];
            bp[k] = pt[k] - vb[k];
            cp[k] = pt[k] - vc[k];
        end
        d1 = dot(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
        d2 = dot(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
        d3 = dot(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
        d4 = dot(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
        d5 = dot(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
        d6 = dot(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
        e1 = d1; e2 = d2; e3 = d3; e4 = d4; e5 = d5; e6 = d6;
        area_c = e1 * e4 - e3 * e2;
        area_b = e5 * e2 - e1 * e6;
        area_a = e3 * e6 - e5 * e4;
        wb = '0;
        wc = '0;
        if (d1 <= 0 && d2 <= 0) begin
            reg_code = ptc_pkg::REG_A;
            for (int k = 0; k < 3; k++) near[k] = va[k] * 256;
        end else if (d3 >= 0 && d4 <= d3) begin
            reg_code = ptc_pkg::REG_B;
            wb = WEIGHT_ONE;
            for (int k = 0; k < 3; k++) near[k] = vb[k] * 256;
        end else if (area_c <= 0 && d1 >= 0 && d3 <= 0) begin
            reg_code = ptc_pkg::REG_AB;
            wb = weight_div(e1, e1 - e3);
            wbl = wb;
            for (int k = 0; k < 3; k++) near[k] = va[k] * 256 + ((wbl * ab[k]) >>> 8);
        end else if (d6 >= 0 && d5 <= d6) begin
            reg_code = ptc_pkg::REG_C;
            wc = WEIGHT_ONE;
            for (int k = 0; k < 3; k++) near[k] = vc[k] * 256;
        end else if (area_b <= 0 && d2 >= 0 && d6 <= 0) begin
            reg_code = ptc_pkg::REG_AC;
            wc = weight_div(e2, e2 - e6);
            wcl = wc;
            for (int k = 0; k < 3; k++) near[k] = va[k] * 256 + ((wcl * ac[k]) >>> 8);
        end else if (area_a <= 0 && (d4 - d3) >= 0 && (d5 - d6) >= 0) begin
            reg_code = ptc_pkg::REG_BC;
            wc = weight_div(e4 - e3, (e4 - e3) + (e5 - e6));
            wb = WEIGHT_ONE - wc;
            wcl = wc;
            for (int k = 0; k < 3; k++) near[k] = vb[k] * 256 + ((wcl * bc[k]) >>> 8);
        end else begin
            reg_code = ptc_pkg::REG_INT;
            wb = weight_div(area_b, area_a + area_b + area_c);
            wc = weight_div(area_c, area_a + area_b + area_c);
            wbl = wb;
            wcl = wc;
            // both terms summed before one floor
            for (int k = 0; k < 3; k++)
                near[k] = va[k] * 256 + ((wbl * ab[k] + wcl * ac[k]) >>> 8);
        end
        res.near_x = near[0][23:0];
        res.near_y = near[1][23:0];
        res.near_z = near[2][23:0];
        res.weight_b = wb;
        res.weight_c = wc;
        res.region = reg_code;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    assign o_pending = expected_points.size();

    // Predict on every accepted input item, compare every accepted result
    always @(posedge i_clk) begin
        t_near_point want;
        if (i_rst_n && i_valid && !o_stall)
            expected_points.push_back(closest_point(i_coord));
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                $display("%0t: result with no item outstanding", $realtime);
                o_fail_count++;
            end else begin
                want = expected_points.pop_front();
                if (o_near_x !== want.near_x) report_mismatch("near_x", o_near_x, want.near_x);
                if (o_near_y !== want.near_y) report_mismatch("near_y", o_near_y, want.near_y);
                if (o_near_z !== want.near_z) report_mismatch("near_z", o_near_z, want.near_z);
                if (o_weight_b !== want.weight_b)
                    report_mismatch("weight_b", o_weight_b, want.weight_b);
                if (o_weight_c !== want.weight_c)
                    report_mismatch("weight_c", o_weight_c, want.weight_c);
                if (o_region !== want.region) report_mismatch("region", o_region, want.region);
            end
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int RANDOM_ITEMS = 1100;
    localparam int STALL_LIMIT  = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid;
    logic signed [15:0] coord [12];
    logic signed [23:0] o_near_x, o_near_y, o_near_z;
    logic [16:0] o_weight_b, o_weight_c;
    logic [2:0] o_region;
    logic quiet = 1'b0;
    int fail_count, pending;
    int idle_cycles = 0;

    initial for (int k = 0; k < 12; k++) coord[k] = '0;

    always #1 i_clk = ~i_clk;

    point_triangle_closest_point_core DUT (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_point_x(coord[0]), .i_point_y(coord[1]), .i_point_z(coord[2]),
        .i_vert_a_x(coord[3]), .i_vert_a_y(coord[4]), .i_vert_a_z(coord[5]),
        .i_vert_b_x(coord[6]), .i_vert_b_y(coord[7]), .i_vert_b_z(coord[8]),
        .i_vert_c_x(coord[9]), .i_vert_c_y(coord[10]), .i_vert_c_z(coord[11]),
        .o_valid, .i_stall, .o_near_x, .o_near_y, .o_near_z,
        .o_weight_b, .o_weight_c, .o_region
    );

    closest_point_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_coord(coord),
        .o_valid, .i_stall, .o_near_x, .o_near_y, .o_near_z,
        .o_weight_b, .o_weight_c, .o_region,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Random output stall
    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(0, 99) < 7);
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && idle_cycles > STALL_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Present one query, with random idle cycles ahead of it
    task automatic send_query(logic signed [15:0] c [12]);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        for (int k = 0; k < 12; k++) coord[k] <= c[k];
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_triangle(int px, int py, int pz, int ax, int ay, int az,
                                 int bx, int by, int bz, int cx, int cy, int cz);
        logic signed [15:0] c [12];
        c = '{px[15:0], py[15:0], pz[15:0], ax[15:0], ay[15:0], az[15:0],
              bx[15:0], by[15:0], bz[15:0], cx[15:0], cy[15:0], cz[15:0]};
        send_query(c);
    endtask

    // Random query: full-range noise, local triangles, or degenerate ones
    task automatic send_random();
        logic signed [15:0] c [12];
        int mode, span, ctr[3];
        mode = $urandom_range(0, 9);
        span = 1 << $urandom_range(1, 13);
        for (int k = 0; k < 3; k++) ctr[k] = $urandom_range(0, 32767) - 16384;
        for (int k = 0; k < 12; k++) begin
            if (mode < 2)
                c[k] = 16'($urandom());
            else
                c[k] = 16'(ctr[k % 3] + $urandom_range(0, 2 * span) - span);
        end
        if (mode == 9) begin
            // collapse a vertex or an edge
            case ($urandom_range(0, 2))
                0: for (int k = 0; k < 3; k++) c[9 + k] = c[3 + k];
                1: for (int k = 0; k < 3; k++) c[6 + k] = c[9 + k];
                default: for (int k = 0; k < 3; k++)
                    c[9 + k] = 16'(2 * c[6 + k] - c[3 + k]);
            endcase
        end
        send_query(c);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A point in every region on a right triangle in the xy plane, two in the interior
        send_triangle(-10, -10, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0);
        send_triangle(110, -5, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0);
        send_triangle(50, -10, 5, 0, 0, 0, 100, 0, 0, 0, 100, 0);
        send_triangle(-5, 110, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0);
        send_triangle(-10, 50, -3, 0, 0, 0, 100, 0, 0, 0, 100, 0);
        send_triangle(60, 60, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0);
        send_triangle(20, 20, 7, 0, 0, 0, 100, 0, 0, 0, 100, 0);
        send_triangle(33, 17, -9, 0, 0, 0, 100, 0, 0, 0, 100, 0);
        // Degenerate triangles: all zero, coincident vertices, collinear
        send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_triangle(5, 5, 5, 1, 1, 1, 1, 1, 1, 1, 1, 1);
        send_triangle(7, 3, 0, 0, 0, 0, 10, 0, 0, 20, 0, 0);
        send_triangle(15, 2, 0, 0, 0, 0, 10, 0, 0, 10, 0, 0);
        // Coordinate extremes
        send_triangle(32767, 32767, 32767, -32768, -32768, -32768,
                      32767, -32768, 32767, -32768, 32767, 32767);
        send_triangle(-32768, -32768, -32768, 32767, 32767, 32767,
                      -32768, 32767, -32768, 32767, -32768, -32768);
        send_triangle(0, 0, 32767, -32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0);
        send_triangle(0, 0, -32768, 32767, 32767, 0, -32768, 32767, 0, 0, -32768, 0);
        send_triangle(-1, -1, -1, -32768, 0, 0, 32767, 0, 0, 0, 32767, 0);
        send_triangle(32767, 0, 0, -32768, 0, 0, 32767, 1, 0, 0, 32767, 1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet <= (n >= 400 && n < 600);
            send_random();
        end
        i_valid <= 1'b0;
        quiet <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ptc_pkg.sv
rtl/core/ptc_geom.sv
rtl/core/ptc_xmul.sv
rtl/core/ptc_div.sv
rtl/core/point_triangle_closest_point_core.sv
tb/sv/closest_point_checker.sv
tb/sv/testbench.sv
